FILE: rtl/core/wtwrs_pkg.sv
// Shared types and constants for the weekly time-window relay scheduler.
// No dependencies; imported by the top level, wtwrs_cell and wtwrs_eval.
package wtwrs_pkg;

	// item function codes
	typedef enum logic [1:0] {
		FN_TICK   = 2'd0,
		FN_ADD    = 2'd1,
		FN_REMOVE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	// what a table cell takes at the next edge
	typedef enum logic [1:0] {
		CS_HOLD,
		CS_NEXT,
		CS_LOAD
	} cell_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	// one window entry, 41 bits
	typedef struct packed {
		logic [7:0]  id;
		logic        enabled;
		logic [6:0]  days;
		logic [10:0] start;
		logic [10:0] stop;
		logic [1:0]  device;
		logic        active;
	} entry_t;

	// control from the sequencer to the data path
	typedef struct packed {
		logic walk;
		logic fire;
	} ctrl_t;

	localparam logic [10:0] MIN_PER_HOUR = 11'd60;
	localparam logic [1:0]  DEV_NONE     = 2'd3;

endpackage

FILE: rtl/core/weekly_time_window_relay_scheduler_top.sv
// Weekly time-window relay scheduler: a ring of MAX_ENTRIES cells rotated past one window test.
// Tick, add and remove walk the whole cell ring before their result is registered; clear goes
// straight to the finish. One item at a time: in_stall holds until its result is registered.
// The walk is a full rotation of the cell ring, one entry per cycle at the head.
// Reset (arst_n low, asynchronous) empties the table and clears the stored relay state.
// Depends on wtwrs_pkg, wtwrs_cell, wtwrs_eval.
module weekly_time_window_relay_scheduler_top
	import wtwrs_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [4:0]  now_hour,
	input  logic [5:0]  now_minute,
	input  logic [2:0]  now_day,
	input  logic [7:0]  entry_id,
	input  logic        entry_enabled,
	input  logic [6:0]  entry_days,
	input  logic [10:0] entry_start,
	input  logic [10:0] entry_end,
	input  logic [1:0]  entry_device,
	input  logic        entry_active,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        fan_on,
	output logic        heater_on,
	output logic        humidifier_on,
	output logic        fan_changed,
	output logic        heater_changed,
	output logic        humidifier_changed,
	output logic        ok,
	output logic [7:0]  assigned_id,
	output logic [4:0]  entry_count
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	state_t         state_q, state_d;
	ctrl_t          ctrl;
	logic           accept;
	func_t          func_q;
	logic [10:0]    cur_q;
	logic [2:0]     day_q;
	entry_t         new_q;
	entry_t         load_entry;
	logic [IW-1:0]  k_q;
	logic [2:0]     acc_q;
	logic [7:0]     max_q;
	logic           found_q;
	logic [IW-1:0]  m_q;
	logic [CW-1:0]  count_q;
	logic [2:0]     relay_q;
	logic           full;
	logic           step_valid;
	logic [2:0]     head_on;
	entry_t         cell_entry [MAX_ENTRIES];
	cell_sel_t      cell_sel   [MAX_ENTRIES];

	logic           out_valid_q;
	logic [2:0]     out_on_q;
	logic [2:0]     out_chg_q;
	logic           out_ok_q;
	logic [7:0]     out_id_q;
	logic [4:0]     out_count_q;

	assign accept     = in_valid && (state_q == ST_IDLE);
	assign full       = (count_q == CW'(MAX_ENTRIES));
	assign step_valid = (CW'(k_q) < count_q);

	assign load_entry = '{
		id:      (new_q.id == 8'd0) ? max_q + 8'd1 : new_q.id,
		enabled: new_q.enabled,
		days:    new_q.days,
		start:   new_q.start,
		stop:    new_q.stop,
		device:  new_q.device,
		active:  new_q.active
	};

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (func_t'(func) == FN_CLEAR) ? ST_FINISH : ST_WALK;
				end
			end
			ST_WALK: begin
				if (k_q == IW'(MAX_ENTRIES - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (ctrl.fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		ctrl.walk = (state_q == ST_WALK);
		ctrl.fire = (state_q == ST_FINISH) && !(out_valid_q && out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func_t'(func);
			cur_q   <= 11'(now_hour) * MIN_PER_HOUR + 11'(now_minute);
			day_q   <= now_day;
			new_q   <= '{id: entry_id, enabled: entry_enabled, days: entry_days,
				start: entry_start, stop: entry_end, device: entry_device,
				active: entry_active};
			k_q     <= '0;
			acc_q   <= '0;
			max_q   <= '0;
			found_q <= 1'b0;
			m_q     <= '0;
		end else if (ctrl.walk) begin
			k_q <= k_q + IW'(1);
			if (step_valid) begin
				acc_q <= acc_q | head_on;
				if (cell_entry[0].id > max_q) begin
					max_q <= cell_entry[0].id;
				end
				// remember the first matching slot
				if (!found_q && (cell_entry[0].id == new_q.id)) begin
					found_q <= 1'b1;
					m_q     <= k_q;
				end
			end
		end
	end

	wtwrs_eval u_eval (
		.entry (cell_entry[0]),
		.cur   (cur_q),
		.day   (day_q),
		.on    (head_on)
	);

	// cell chain: rotate during the walk, load or close the gap at the finish
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		localparam int NXT = (i + 1) % MAX_ENTRIES;

		always_comb begin
			cell_sel[i] = CS_HOLD;
			if (ctrl.walk) begin
				cell_sel[i] = CS_NEXT;
			end else if (ctrl.fire) begin
				if ((func_q == FN_ADD) && !full && (CW'(i) == count_q)) begin
					cell_sel[i] = CS_LOAD;
				end else if ((func_q == FN_REMOVE) && found_q && (IW'(i) >= m_q)) begin
					cell_sel[i] = CS_NEXT;
				end
			end
		end

		wtwrs_cell u_cell (
			.clk        (clk),
			.sel        (cell_sel[i]),
			.next_entry (cell_entry[NXT]),
			.load_entry (load_entry),
			.entry_q    (cell_entry[i])
		);
	end

	// table count and relay state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			relay_q <= '0;
		end else if (ctrl.fire) begin
			case (func_q)
				FN_TICK:   relay_q <= acc_q;
				FN_ADD:    if (!full) count_q <= count_q + CW'(1);
				FN_REMOVE: if (found_q) count_q <= count_q - CW'(1);
				default:   count_q <= '0;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			case (func_q)
				FN_TICK: begin
					out_on_q    <= acc_q;
					out_chg_q   <= acc_q ^ relay_q;
					out_ok_q    <= 1'b1;
					out_id_q    <= '0;
					out_count_q <= 5'(count_q);
				end
				FN_ADD: begin
					out_on_q    <= relay_q;
					out_chg_q   <= '0;
					out_ok_q    <= !full;
					out_id_q    <= full ? 8'd0 : load_entry.id;
					out_count_q <= full ? 5'(count_q) : 5'(count_q + CW'(1));
				end
				FN_REMOVE: begin
					out_on_q    <= relay_q;
					out_chg_q   <= '0;
					out_ok_q    <= found_q;
					out_id_q    <= '0;
					out_count_q <= found_q ? 5'(count_q - CW'(1)) : 5'(count_q);
				end
				default: begin
					out_on_q    <= relay_q;
					out_chg_q   <= '0;
					out_ok_q    <= 1'b1;
					out_id_q    <= '0;
					out_count_q <= '0;
				end
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign fan_on             = out_on_q[0];
	assign heater_on          = out_on_q[1];
	assign humidifier_on      = out_on_q[2];
	assign fan_changed        = out_chg_q[0];
	assign heater_changed     = out_chg_q[1];
	assign humidifier_changed = out_chg_q[2];
	assign ok                 = out_ok_q;
	assign assigned_id        = out_id_q;
	assign entry_count        = out_count_q;

endmodule

FILE: rtl/core/wtwrs_cell.sv
// One table cell: holds a window entry and takes its neighbor's or a new one.
// Depends on wtwrs_pkg.
module wtwrs_cell
	import wtwrs_pkg::*;
(
	input  logic      clk,
	input  cell_sel_t sel,
	input  entry_t    next_entry,
	input  entry_t    load_entry,
	output entry_t    entry_q
);

	always_ff @(posedge clk) begin
		case (sel)
			CS_NEXT: entry_q <= next_entry;
			CS_LOAD: entry_q <= load_entry;
			default: entry_q <= entry_q;
		endcase
	end

endmodule

FILE: rtl/core/wtwrs_eval.sv
// Window test for the entry at the head of the cell chain.
// Depends on wtwrs_pkg.
module wtwrs_eval
	import wtwrs_pkg::*;
(
	input  entry_t      entry,
	input  logic [10:0] cur,
	input  logic [2:0]  day,
	output logic [2:0]  on
);

	logic [7:0] day_mask;
	logic       holds;
	logic       hit;

	assign day_mask = {1'b0, entry.days};

	always_comb begin
		if (entry.start < entry.stop) begin
			holds = (cur >= entry.start) && (cur < entry.stop);
		end else begin
			// window wraps past midnight
			holds = (cur >= entry.start) || (cur < entry.stop);
		end
		hit = entry.enabled && day_mask[day] && holds && entry.active
			&& (entry.device != DEV_NONE);
		on = hit ? (3'b001 << entry.device) : 3'b000;
	end

endmodule

FILE: rtl/core/wtwrs_checker.sv
// Port-level checks for the weekly time-window relay scheduler, bound to the top level.
// Depends on weekly_time_window_relay_scheduler_top.
module wtwrs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       fan_on,
	input logic       heater_on,
	input logic       humidifier_on,
	input logic       fan_changed,
	input logic       heater_changed,
	input logic       humidifier_changed,
	input logic       ok,
	input logic [7:0] assigned_id,
	input logic [4:0] entry_count
);

	// a stalled result word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(entry_count) && $stable(assigned_id))
		else $error("stalled result word changed");

	// a nonzero id is only reported by a successful add
	a_id_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (assigned_id != 8'd0) |-> ok)
		else $error("assigned id without success");

	// a change flag only comes with a tick, which always succeeds
	a_chg_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fan_changed || heater_changed || humidifier_changed) |-> ok
			&& (assigned_id == 8'd0))
		else $error("change flag on a non-tick word");

	// an accepted input word keeps in_stall high in the next cycle
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

endmodule

bind weekly_time_window_relay_scheduler_top wtwrs_checker u_wtwrs_checker (.*);
